// ----- hdl/wfc_pkg.sv -----
`default_nettype none
package wfc_pkg;

  typedef enum logic {
    ACT_DECODE,
    ACT_ENCODE
  } action_t;

  typedef enum logic [1:0] {
    FMT_H10301,
    FMT_CORP35,
    FMT_H10302,
    FMT_H10304
  } fmt_t;

  localparam logic [6:0] LEN_H10301 = 7'd26;
  localparam logic [6:0] LEN_CORP35 = 7'd35;
  localparam logic [6:0] LEN_H37    = 7'd37;

  // Parity masks of the 35-bit corporate format over the bottom word.
  localparam logic [31:0] MASK_EVEN_CORP = 32'hB6DB6DB6;
  localparam logic [31:0] MASK_ODD_CORP  = 32'h6DB6DB6C;

  typedef struct packed {
    action_t      action;
    fmt_t         format;
    logic [15:0]  facility_in;
    logic [34:0]  card_in;
    logic [63:0]  message_in;
    logic [6:0]   length_in;
  } in_item_t;

  typedef struct packed {
    logic [63:0]  message_out;
    logic [6:0]   length_out;
    logic [15:0]  facility_out;
    logic [34:0]  card_out;
    logic         length_match;
    logic         valid_res;
  } out_item_t;

  function automatic logic [6:0] len_of(input fmt_t fmt);
    logic [6:0] len;
    case (fmt)
      FMT_H10301: len = LEN_H10301;
      FMT_CORP35: len = LEN_CORP35;
      default:    len = LEN_H37;
    endcase
    return len;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/wfc_in_if.sv -----
`default_nettype none
interface wfc_in_if;
  logic               valid;
  logic               ready;
  wfc_pkg::in_item_t  data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/wfc_out_if.sv -----
`default_nettype none
interface wfc_out_if;
  logic               valid;
  logic               ready;
  wfc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/wiegand_format_codec.sv -----
`default_nettype none
// An accepted input beat reaches its result beat through the input register,
// then the result register.
// Throughput: one item per cycle while out_ch is ready; a stalled result holds
// the result register while the input register can still take one more beat.
// Reset: synchronous active-low rst_n empties both registers.
module wiegand_format_codec (
  input wire        clk,
  input wire        rst_n,
  wfc_in_if.sink    in_ch,
  wfc_out_if.source out_ch
);
  import wfc_pkg::*;

  in_item_t  in_q_r;
  logic      s1_v_r;
  out_item_t out_q_r;
  logic      out_v_r;

  out_item_t enc_res;
  out_item_t dec_res;
  out_item_t res_nxt;
  logic      adv;
  logic      in_rdy;

  wfc_encode u_enc (.item(in_q_r), .res(enc_res));
  wfc_decode u_dec (.item(in_q_r), .res(dec_res));

  assign res_nxt = (in_q_r.action == ACT_ENCODE) ? enc_res : dec_res;

  // The result register moves when it is empty or being drained this cycle.
  assign adv    = !out_v_r || out_ch.ready;
  assign in_rdy = !s1_v_r || adv;

  assign in_ch.ready  = in_rdy;
  assign out_ch.valid = out_v_r;
  assign out_ch.data  = out_q_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (in_rdy) begin
        s1_v_r <= in_ch.valid;
      end
      if (adv) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      in_q_r <= in_ch.data;
    end
    if (adv && s1_v_r) begin
      out_q_r <= res_nxt;
    end
  end

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_rdy |-> (s1_v_r && out_v_r))
    else $error("input stalled while a register is empty");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_rdy) |=> s1_v_r)
    else $error("accepted beat not held in the input register");

  a_encode_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && (out_q_r.length_out != 7'd0)) |->
      (out_q_r.valid_res && out_q_r.length_match && (out_q_r.facility_out == 16'd0)))
    else $error("encode result carries decode fields");

  a_valid_needs_length: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_q_r.valid_res) |-> out_q_r.length_match)
    else $error("valid result without a length match");

endmodule
`default_nettype wire

// ----- hdl/wfc_encode.sv -----
`default_nettype none
module wfc_encode (
  input  wire  wfc_pkg::in_item_t  item,
  output       wfc_pkg::out_item_t res
);
  import wfc_pkg::*;

  logic [63:0] m;
  logic [31:0] bot;
  logic [2:0]  mid;

  always_comb begin
    m   = '0;
    bot = '0;
    mid = '0;
    case (item.format)
      FMT_H10301: begin
        m[16:1]  = item.card_in[15:0];
        m[24:17] = item.facility_in[7:0];
        m[0]     = ~(^m[12:1]);
        m[25]    = ^m[24:13];
      end
      FMT_CORP35: begin
        bot[20:1]  = item.card_in[19:0];
        bot[31:21] = item.facility_in[10:0];
        mid[0]     = item.facility_in[11];
        mid[1]     = mid[0] ^ (^(bot & MASK_EVEN_CORP));
        bot[0]     = ~(mid[0] ^ mid[1] ^ (^(bot & MASK_ODD_CORP)));
        // The last parity bit covers every other bit of the message, including the bit just set.
        mid[2]     = ~(mid[0] ^ mid[1] ^ (^bot));
        m          = {29'd0, mid, bot};
      end
      default: begin
        if (item.format == FMT_H10302) begin
          m[35:1] = item.card_in;
        end else begin
          m[35:20] = item.facility_in;
          m[19:1]  = item.card_in[18:0];
        end
        m[36] = ^m[35:18];
        m[0]  = ~(^m[18:1]);
      end
    endcase
  end

  always_comb begin
    res              = '0;
    res.message_out  = m;
    res.length_out   = len_of(item.format);
    res.length_match = 1'b1;
    res.valid_res    = 1'b1;
  end

endmodule
`default_nettype wire

// ----- hdl/wfc_decode.sv -----
`default_nettype none
module wfc_decode (
  input  wire  wfc_pkg::in_item_t  item,
  output       wfc_pkg::out_item_t res
);
  import wfc_pkg::*;

  logic [63:0] msg;
  logic        match;
  logic        p_a;
  logic        p_b;
  logic        p_c;
  logic        ok;
  logic [15:0] fac;
  logic [34:0] card;

  assign msg   = item.message_in;
  assign match = (item.length_in == len_of(item.format));

  always_comb begin
    fac  = '0;
    card = '0;
    p_a  = 1'b0;
    p_b  = 1'b0;
    p_c  = 1'b0;
    ok   = 1'b0;
    case (item.format)
      FMT_H10301: begin
        card = {19'd0, msg[16:1]};
        fac  = {8'd0, msg[24:17]};
        p_a  = ~(^msg[12:1]);
        p_b  = ^msg[24:13];
        ok   = (p_a == msg[0]) && (p_b == msg[25]);
      end
      FMT_CORP35: begin
        card = {15'd0, msg[20:1]};
        fac  = {4'd0, msg[32], msg[31:21]};
        p_a  = msg[32] ^ (^(msg[31:0] & MASK_EVEN_CORP));
        p_b  = ~(msg[32] ^ msg[33] ^ (^(msg[31:0] & MASK_ODD_CORP)));
        p_c  = ~(msg[32] ^ msg[33] ^ (^msg[31:0]));
        ok   = (p_a == msg[33]) && (p_b == msg[0]) && (p_c == msg[34]);
      end
      default: begin
        if (item.format == FMT_H10302) begin
          card = msg[35:1];
        end else begin
          fac  = msg[35:20];
          card = {16'd0, msg[19:1]};
        end
        p_a = ^msg[35:18];
        p_b = ~(^msg[18:1]);
        ok  = (p_a == msg[36]) && (p_b == msg[0]);
      end
    endcase
  end

  always_comb begin
    res              = '0;
    res.facility_out = match ? fac : 16'd0;
    res.card_out     = match ? card : 35'd0;
    res.length_match = match;
    res.valid_res    = match && ok;
  end

endmodule
`default_nettype wire

// ----- tb/wiegand_result_check.sv -----
`timescale 1ns / 100ps
module wiegand_result_check (
  input  wire       clk,
  input  wire       rst_n,
  wfc_in_if         in_mon,
  wfc_out_if        out_mon,
  output int        mismatches,
  output int        outstanding
);
  import wfc_pkg::*;

  out_item_t codec_results_due[$];

  initial begin
    mismatches = 0;
    outstanding = 0;
  end

  function automatic out_item_t wiegand_codec_predict(input in_item_t beat);
    out_item_t  res;
    logic [25:0] w26;
    logic [31:0] bot;
    logic [2:0]  mid;
    logic [36:0] w37;
    logic [6:0]  frame_len;
    res = '0;
    w26 = '0;
    bot = '0;
    mid = '0;
    w37 = '0;
    case (beat.format)
      FMT_H10301: frame_len = LEN_H10301;
      FMT_CORP35: frame_len = LEN_CORP35;
      default:    frame_len = LEN_H37;
    endcase

    if (beat.action == ACT_ENCODE) begin
      res.length_out = frame_len;
      res.length_match = 1'b1;
      res.valid_res = 1'b1;
      case (beat.format)
        FMT_H10301: begin
          w26[16:1] = beat.card_in[15:0];
          w26[24:17] = beat.facility_in[7:0];
          w26[0] = ~^w26[12:1];
          w26[25] = ^w26[24:13];
          res.message_out = {38'd0, w26};
        end
        FMT_CORP35: begin
          bot[20:1] = beat.card_in[19:0];
          bot[31:21] = beat.facility_in[10:0];
          mid[0] = beat.facility_in[11];
          mid[1] = mid[0] ^ (^(bot & MASK_EVEN_CORP));
          bot[0] = ~((^mid[1:0]) ^ (^(bot & MASK_ODD_CORP)));
          // The last parity bit covers the bottom word and mid[1:0], including the parity bit bot[0].
          mid[2] = ~((^mid[1:0]) ^ (^bot));
          res.message_out = {29'd0, mid, bot};
        end
        default: begin
          if (beat.format == FMT_H10302) begin
            w37[35:1] = beat.card_in;
          end else begin
            w37[35:20] = beat.facility_in;
            w37[19:1] = beat.card_in[18:0];
          end
          w37[36] = ^w37[35:18];
          w37[0] = ~^w37[18:1];
          res.message_out = {27'd0, w37};
        end
      endcase
    end else if (beat.length_in == frame_len) begin
      res.length_match = 1'b1;
      case (beat.format)
        FMT_H10301: begin
          res.card_out = {19'd0, beat.message_in[16:1]};
          res.facility_out = {8'd0, beat.message_in[24:17]};
          res.valid_res = (beat.message_in[0] == (~^beat.message_in[12:1])) &&
                          (beat.message_in[25] == (^beat.message_in[24:13]));
        end
        FMT_CORP35: begin
          bot = beat.message_in[31:0];
          mid = beat.message_in[34:32];
          res.card_out = {15'd0, bot[20:1]};
          res.facility_out = {4'd0, mid[0], bot[31:21]};
          res.valid_res = (mid[1] == (mid[0] ^ (^(bot & MASK_EVEN_CORP)))) &&
                          (bot[0] == ~((^mid[1:0]) ^ (^(bot & MASK_ODD_CORP)))) &&
                          (mid[2] == ~((^mid[1:0]) ^ (^bot)));
        end
        default: begin
          if (beat.format == FMT_H10302) begin
            res.card_out = beat.message_in[35:1];
          end else begin
            res.facility_out = beat.message_in[35:20];
            res.card_out = {16'd0, beat.message_in[19:1]};
          end
          res.valid_res = (beat.message_in[36] == (^beat.message_in[35:18])) &&
                          (beat.message_in[0] == (~^beat.message_in[18:1]));
        end
      endcase
    end
    return res;
  endfunction

  task automatic report(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic check_field(input string field, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report($sformatf("%s got %0h, expected %0h", field, got, want));
  endtask

  always @(posedge clk) begin : watch
    out_item_t want;
    out_item_t got;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready) codec_results_due.push_back(wiegand_codec_predict(in_mon.data));
      if (out_mon.valid && out_mon.ready) begin
        got = out_mon.data;
        if (codec_results_due.size() == 0) begin
          report("result beat with no result due");
        end else begin
          want = codec_results_due.pop_front();
          check_field("message_out", got.message_out, want.message_out);
          check_field("length_out", 64'(got.length_out), 64'(want.length_out));
          check_field("facility_out", 64'(got.facility_out), 64'(want.facility_out));
          check_field("card_out", 64'(got.card_out), 64'(want.card_out));
          check_field("length_match", 64'(got.length_match), 64'(want.length_match));
          check_field("valid_res", 64'(got.valid_res), 64'(want.valid_res));
        end
      end
      outstanding = codec_results_due.size();
    end
  end

endmodule

// ----- tb/wiegand_format_codec_test.sv -----
`timescale 1ns / 100ps
module wiegand_format_codec_test;
  import wfc_pkg::*;

  localparam int ITEMS       = 1800;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;

  logic clk;
  logic rst_n;
  int   mismatches;
  int   outstanding;
  int   cycles = 0;
  bit   idle_en = 1'b1;
  bit   hold_req = 1'b0;

  wfc_in_if  in_ch ();
  wfc_out_if out_ch ();

  wiegand_format_codec DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  wiegand_result_check result_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("wiegand_format_codec_test NOT OK");
      $finish;
    end
  end

  function automatic in_item_t make_beat(input action_t act, input fmt_t fmt,
                                         input logic [15:0] fac, input logic [34:0] card,
                                         input logic [63:0] msg, input logic [6:0] len);
    in_item_t beat;
    beat.action = act;
    beat.format = fmt;
    beat.facility_in = fac;
    beat.card_in = card;
    beat.message_in = msg;
    beat.length_in = len;
    return beat;
  endfunction

  function automatic in_item_t random_beat();
    in_item_t beat;
    beat.action = $urandom_range(0, 1) ? ACT_ENCODE : ACT_DECODE;
    beat.format = fmt_t'($urandom_range(0, 3));
    beat.facility_in = 16'($urandom);
    beat.card_in = 35'({$urandom, $urandom});
    beat.message_in = {$urandom, $urandom};
    // Most frames to decode carry the right length, so that parity gets checked.
    if ($urandom_range(0, 9) < 2) beat.length_in = 7'($urandom_range(0, 96));
    else beat.length_in = len_of(beat.format);
    if ($urandom_range(0, 1)) beat.message_in &= (64'd1 << beat.length_in) - 64'd1;
    return beat;
  endfunction

  task automatic send_beat(input in_item_t beat);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= beat;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
  endtask

  // Result side: random stalls, and one long hold-off while the sender keeps going.
  initial begin : sink_side
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    repeat (2) @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (idle_en && $urandom_range(0, 2) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      if (idle_en) repeat ($urandom_range(1, 40)) @(posedge clk);
      else @(posedge clk);
    end
  end

  initial begin : source_side
    logic [63:0] good_frame [4];
    logic [6:0]  wrong_len [4];
    logic [63:0] above_len;
    logic [6:0]  flen;
    fmt_t        fmt;
    int          n;
    // Frames with all field bits set and correct parity.
    good_frame[0] = 64'h0000_0000_01FF_FFFF;
    good_frame[1] = 64'h0000_0005_FFFF_FFFE;
    good_frame[2] = 64'h0000_000F_FFFF_FFFF;
    good_frame[3] = 64'h0000_000F_FFFF_FFFF;
    wrong_len[0] = 7'd0;
    wrong_len[1] = 7'd34;
    wrong_len[2] = 7'd38;
    wrong_len[3] = 7'd96;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    for (n = 0; n < 4; n++) begin
      fmt = fmt_t'(n);
      flen = len_of(fmt);
      above_len = ~((64'd1 << flen) - 64'd1);
      send_beat(make_beat(ACT_ENCODE, fmt, '1, '1, '0, '0));
      send_beat(make_beat(ACT_ENCODE, fmt, '0, '0, '1, 7'd96));
      send_beat(make_beat(ACT_DECODE, fmt, '1, '1, good_frame[n], flen));
      // Bits above the frame length must not matter.
      send_beat(make_beat(ACT_DECODE, fmt, '0, '0, 64'd1 | above_len, flen));
      send_beat(make_beat(ACT_DECODE, fmt, '0, '0, good_frame[n] ^ 64'd1, flen));
      send_beat(make_beat(ACT_DECODE, fmt, '0, '0, good_frame[n], wrong_len[n]));
    end

    for (n = 0; n < ITEMS; n++) begin
      if (n == 500) hold_req = 1'b1;
      if (n == ITEMS - 300) idle_en = 1'b0;
      send_beat(random_beat());
    end
    in_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("wiegand_format_codec_test OK");
    end else begin
      $display("wiegand_format_codec_test NOT OK");
    end
    $finish;
  end

endmodule
